### design/ffba_pkg.sv
// ffba_pkg: shared types and constants of the first-fit block allocator
// used by ffba_ctrl, ffba_dp and first_fit_block_allocator_unit; no dependencies
`default_nettype none

package ffba_pkg;

  // field widths
  localparam int unsigned REQ_W   = 23;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned BIU_W   = 11;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned ENTRY_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'b1;

  // register reset values
  localparam logic [ADDR_W-1:0] HEAP_BASE_RST     = 32'h0;
  localparam logic [BIU_W-1:0]  BLOCKS_IN_USE_RST = 11'd1024;

  // block table entry marks
  localparam logic [3:0]         TYPE_MASK     = 4'hf;
  localparam logic [ENTRY_W-1:0] MARK_FREE     = 3'b000;
  localparam logic [ENTRY_W-1:0] MARK_TAKEN    = 3'b001;
  localparam logic [ENTRY_W-1:0] MARK_FIRST    = 3'b010;
  localparam logic [ENTRY_W-1:0] MARK_HAS_NEXT = 3'b100;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_ZERO     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_FINISH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    clear;
    logic    start;
    logic    scan;
    logic    mark;
    logic    load_out;
    status_e code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic zero_req;
    logic found;
    logic fail;
    logic mark_last;
  } stat_t;

endpackage

`default_nettype wire

### design/first_fit_block_allocator_unit.sv
// first_fit_block_allocator_unit: top level of the first-fit block allocator
// depends on ffba_pkg, ffba_ctrl and ffba_dp
`default_nettype none

// First-fit block allocator. Each input item is a request in bytes; the block
// walks a table of NUM_BLOCKS entries from entry 0, one entry a cycle out of a
// single-port-read table memory, and stops at the first run of free entries
// whose size in BLOCK_BYTES blocks covers the request. That run is then marked
// taken, one entry a cycle, and the result item carries heap_base plus the run
// start times BLOCK_BYTES (wrapping at 32 bits) with status 0. Status 1 means
// no run fit inside the covered entries, status 2 a zero-size request; both
// return address zero and leave the table alone. A request that finds a run
// scans entries up to and including the last entry of the run, then marks the
// run; a request that fails scans every covered entry (blocks_in_use saturated
// at NUM_BLOCKS) and then a check finds the end of the covered entries; a
// zero-size request scans nothing. Each is held in its last step while the
// previous result still waits in the output register. The next request is
// taken as soon as the current result sits in the output register, even if
// that result has not been picked up yet. After reset the table is cleared by
// a pass over all NUM_BLOCKS entries during which no request is taken;
// configuration writes are taken at any time and should only be issued while
// idle.

module first_fit_block_allocator_unit #(
  parameter int unsigned NUM_BLOCKS  = 1024,
  parameter int unsigned BLOCK_BYTES = 4096
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // configuration write port
  input  wire                             cfg_we_i,
  input  wire  [ffba_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [ffba_pkg::CFG_W-1:0]      cfg_data_i,
  // request item
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire  [ffba_pkg::REQ_W-1:0]      request_bytes_i,
  // result item
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic [ffba_pkg::ADDR_W-1:0]     block_address_o,
  output logic [1:0]                      status_o
);

  // commands and status between sequencer and datapath
  ffba_pkg::cmd_t  cmd;
  ffba_pkg::stat_t stat;

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // table memory, scan counters, run tracking and output register
  ffba_dp #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .request_bytes_i (request_bytes_i),
    .block_address_o (block_address_o),
    .status_o        (status_o),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

endmodule

`default_nettype wire

### design/ffba_ctrl.sv
// ffba_ctrl: sequencer of the allocator (clear pass, scan, mark, result hand-off)
// depends on ffba_pkg
`default_nettype none

module ffba_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  input  ffba_pkg::stat_t stat_i,
  output ffba_pkg::cmd_t  cmd_o
);

  ffba_pkg::state_e  state_q, state_d;
  ffba_pkg::status_e res_q, res_d;
  logic              out_valid_q, out_valid_d;
  logic              slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    unique case (state_q)
      ffba_pkg::S_CLEAR: begin
        if (stat_i.clear_done) state_d = ffba_pkg::S_IDLE;
      end
      ffba_pkg::S_IDLE: begin
        if (in_valid_i) state_d = ffba_pkg::S_SCAN;
      end
      ffba_pkg::S_SCAN: begin
        if (stat_i.zero_req) begin
          res_d   = ffba_pkg::ST_ZERO;
          state_d = ffba_pkg::S_FINISH;
        end else if (stat_i.found) begin
          state_d = ffba_pkg::S_MARK;
        end else if (stat_i.fail) begin
          res_d   = ffba_pkg::ST_NO_SPACE;
          state_d = ffba_pkg::S_FINISH;
        end
      end
      ffba_pkg::S_MARK: begin
        if (stat_i.mark_last) begin
          res_d   = ffba_pkg::ST_OK;
          state_d = ffba_pkg::S_FINISH;
        end
      end
      ffba_pkg::S_FINISH: begin
        if (slot_free) state_d = ffba_pkg::S_IDLE;
      end
      default: state_d = ffba_pkg::S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.code = res_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ffba_pkg::S_CLEAR: cmd_o.clear = 1'b1;
      ffba_pkg::S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      ffba_pkg::S_SCAN:   cmd_o.scan = !stat_i.zero_req;
      ffba_pkg::S_MARK:   cmd_o.mark = 1'b1;
      ffba_pkg::S_FINISH: cmd_o.load_out = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffba_pkg::S_CLEAR;
      res_q       <= ffba_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### design/ffba_dp.sv
// ffba_dp: block table memory, scan and mark counters, config and result registers
// depends on ffba_pkg
`default_nettype none

module ffba_dp #(
  parameter int unsigned NUM_BLOCKS  = 1024,
  parameter int unsigned BLOCK_BYTES = 4096
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [ffba_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [ffba_pkg::CFG_W-1:0]         cfg_data_i,
  input  wire  [ffba_pkg::REQ_W-1:0]         request_bytes_i,
  output logic [ffba_pkg::ADDR_W-1:0]        block_address_o,
  output logic [1:0]                         status_o,
  input  ffba_pkg::cmd_t                     cmd_i,
  output ffba_pkg::stat_t                    stat_o
);

  localparam int unsigned IW = $clog2(NUM_BLOCKS);
  localparam int unsigned CW = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned LW = (CW > ffba_pkg::BIU_W) ? CW : ffba_pkg::BIU_W;
  localparam int unsigned RW = $clog2((2 ** ffba_pkg::REQ_W) + BLOCK_BYTES);
  localparam logic [RW-1:0] BB_RUN = RW'(BLOCK_BYTES);
  localparam logic [ffba_pkg::ADDR_W-1:0] BB_ADDR = ffba_pkg::ADDR_W'(BLOCK_BYTES);
  localparam logic [LW-1:0] NB_L = LW'(NUM_BLOCKS);
  localparam logic [CW-1:0] NB_C = CW'(NUM_BLOCKS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BLOCKS - 1);

  // configuration registers
  logic [ffba_pkg::ADDR_W-1:0] heap_base_q;
  logic [ffba_pkg::BIU_W-1:0]  biu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= ffba_pkg::HEAP_BASE_RST;
      biu_q       <= ffba_pkg::BLOCKS_IN_USE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ffba_pkg::REG_HEAP_BASE:     heap_base_q <= cfg_data_i;
        ffba_pkg::REG_BLOCKS_IN_USE: biu_q <= cfg_data_i[ffba_pkg::BIU_W-1:0];
        default: ;
      endcase
    end
  end

  // covered entries, saturated at table size
  logic [LW-1:0] biu_ext, limit;
  assign biu_ext = LW'(biu_q);
  assign limit   = (biu_ext > NB_L) ? NB_L : biu_ext;

  // block table
  logic [ffba_pkg::ENTRY_W-1:0] mem [NUM_BLOCKS];
  logic [ffba_pkg::ENTRY_W-1:0] rdata_q, wdata;
  logic [IW-1:0]                waddr;
  logic                         we, re;

  // scan state
  logic [ffba_pkg::REQ_W-1:0]  bytes_q;
  logic [CW-1:0]               issue_cnt_q, proc_cnt_q;
  logic                        pv_q;
  logic [RW-1:0]               run_bytes_q, run_next;
  logic [IW-1:0]               start_idx_q, end_idx_q, mark_idx_q, clr_idx_q;
  logic [ffba_pkg::ADDR_W-1:0] cur_addr_q, start_addr_q, run_start_addr;
  logic [IW-1:0]               proc_idx, run_start_idx;
  logic                        entry_free, past_limit, do_entry;

  // result registers
  logic [ffba_pkg::ADDR_W-1:0] block_address_q;
  ffba_pkg::status_e           status_q;

  assign re = cmd_i.scan && (issue_cnt_q < NB_C);

  assign proc_idx   = proc_cnt_q[IW-1:0];
  assign entry_free = (({1'b0, rdata_q} & ffba_pkg::TYPE_MASK &
                        {1'b0, ffba_pkg::MARK_TAKEN}) == 4'h0);
  assign past_limit = (LW'(proc_cnt_q) >= limit);
  assign do_entry   = cmd_i.scan && pv_q && !past_limit;

  // a new run opens at this entry when no free entries are pending
  assign run_start_idx  = (run_bytes_q == '0) ? proc_idx : start_idx_q;
  assign run_start_addr = (run_bytes_q == '0) ? cur_addr_q : start_addr_q;
  assign run_next       = run_bytes_q + BB_RUN;

  assign stat_o.clear_done = cmd_i.clear && (clr_idx_q == LAST_IDX);
  assign stat_o.zero_req   = (bytes_q == '0);
  assign stat_o.found      = do_entry && entry_free &&
                             (run_next >= RW'(bytes_q));
  assign stat_o.fail       = cmd_i.scan && pv_q && past_limit;
  assign stat_o.mark_last  = cmd_i.mark && (mark_idx_q == end_idx_q);

  // write port: clear pass or run marking
  always_comb begin
    we    = cmd_i.clear || cmd_i.mark;
    waddr = cmd_i.clear ? clr_idx_q : mark_idx_q;
    wdata = ffba_pkg::MARK_TAKEN;
    if (mark_idx_q == start_idx_q) wdata = wdata | ffba_pkg::MARK_FIRST;
    if (mark_idx_q != end_idx_q) wdata = wdata | ffba_pkg::MARK_HAS_NEXT;
    if (cmd_i.clear) wdata = ffba_pkg::MARK_FREE;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[issue_cnt_q[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q   <= '0;
      issue_cnt_q <= '0;
      proc_cnt_q  <= '0;
      pv_q        <= 1'b0;
      mark_idx_q  <= '0;
    end else begin
      if (cmd_i.clear) clr_idx_q <= clr_idx_q + 1'b1;
      if (cmd_i.start) begin
        issue_cnt_q <= '0;
        pv_q        <= 1'b0;
      end else if (cmd_i.scan) begin
        if (re) issue_cnt_q <= issue_cnt_q + 1'b1;
        proc_cnt_q <= issue_cnt_q;
        pv_q       <= 1'b1;
      end else begin
        pv_q <= 1'b0;
      end
      if (stat_o.found) mark_idx_q <= run_start_idx;
      else if (cmd_i.mark) mark_idx_q <= mark_idx_q + 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      bytes_q     <= request_bytes_i;
      run_bytes_q <= '0;
      cur_addr_q  <= heap_base_q;
    end else if (do_entry) begin
      cur_addr_q <= cur_addr_q + BB_ADDR;
      if (entry_free) begin
        run_bytes_q  <= run_next;
        start_idx_q  <= run_start_idx;
        start_addr_q <= run_start_addr;
        end_idx_q    <= proc_idx;
      end else begin
        run_bytes_q <= '0;
      end
    end
    if (cmd_i.load_out) begin
      status_q        <= cmd_i.code;
      block_address_q <= (cmd_i.code == ffba_pkg::ST_OK) ? start_addr_q : '0;
    end
  end

  assign block_address_o = block_address_q;
  assign status_o        = status_q;

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench of first_fit_block_allocator_unit
// drives request items and register writes, checks each result item against a shadow table
// depends on ffba_pkg and the allocator rtl

module tb;

  localparam int unsigned NUM_BLOCKS  = 1024;
  localparam int unsigned BLOCK_BYTES = 4096;

  // every input of the block starts at a known value
  logic                           clk          = 1'b0;
  logic                           rst_n        = 1'b0;
  logic                           cfg_we       = 1'b0;
  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
  logic [ffba_pkg::CFG_W-1:0]     cfg_data     = '0;
  logic                           in_valid     = 1'b0;
  logic                           in_ready;
  logic [ffba_pkg::REQ_W-1:0]     req_bytes    = '0;
  logic                           out_valid;
  logic                           out_ready    = 1'b0;
  logic [ffba_pkg::ADDR_W-1:0]    block_address;
  logic [1:0]                     status;

  // burst flags: while set, that side takes no idle cycles
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  typedef struct packed {
    logic [ffba_pkg::ADDR_W-1:0] addr;
    ffba_pkg::status_e           status;
  } grant_t;

  // shadow of the block table and registers, plus the grants still owed by the block
  class alloc_ledger;
    logic [ffba_pkg::ENTRY_W-1:0] shadow_table [NUM_BLOCKS];
    logic [ffba_pkg::ADDR_W-1:0]  heap_base;
    logic [ffba_pkg::BIU_W-1:0]   blocks_in_use;
    grant_t                       owed_grants [$];
    int unsigned                  errors;

    function new();
      foreach (shadow_table[i]) shadow_table[i] = ffba_pkg::MARK_FREE;
      heap_base     = ffba_pkg::HEAP_BASE_RST;
      blocks_in_use = ffba_pkg::BLOCKS_IN_USE_RST;
      errors        = 0;
    endfunction

    function void write_reg(logic [ffba_pkg::CFG_IDX_W-1:0] idx,
                            logic [ffba_pkg::CFG_W-1:0] data);
      case (idx)
        ffba_pkg::REG_HEAP_BASE:     heap_base = data;
        ffba_pkg::REG_BLOCKS_IN_USE: blocks_in_use = data[ffba_pkg::BIU_W-1:0];
        default: ;
      endcase
    endfunction

    // round up to blocks, find the first free run inside the covered entries, mark it
    function grant_t first_fit_grant(logic [ffba_pkg::REQ_W-1:0] bytes);
      grant_t      g;
      int unsigned nbytes, nblk, limit, run, first;
      bit          hit;
      g.addr   = '0;
      g.status = ffba_pkg::ST_OK;
      run      = 0;
      first    = 0;
      hit      = 1'b0;
      nbytes   = bytes;
      nblk     = (nbytes + BLOCK_BYTES - 1) / BLOCK_BYTES;
      // coverage above the table size saturates
      limit    = (blocks_in_use > NUM_BLOCKS) ? NUM_BLOCKS : blocks_in_use;
      if (nblk == 0) begin
        g.status = ffba_pkg::ST_ZERO;
      end else begin
        if (nblk <= limit) begin
          for (int unsigned i = 0; i < limit && !hit; i++) begin
            if ((shadow_table[i] & ffba_pkg::MARK_TAKEN) != ffba_pkg::MARK_FREE) begin
              run = 0;
            end else begin
              if (run == 0) first = i;
              run++;
              if (run == nblk) hit = 1'b1;
            end
          end
        end
        if (!hit) begin
          g.status = ffba_pkg::ST_NO_SPACE;
        end else begin
          for (int unsigned k = 0; k < nblk; k++) begin
            shadow_table[first + k] =
                ffba_pkg::MARK_TAKEN
              | ((k == 0) ? ffba_pkg::MARK_FIRST : ffba_pkg::MARK_FREE)
              | ((k + 1 < nblk) ? ffba_pkg::MARK_HAS_NEXT : ffba_pkg::MARK_FREE);
          end
          // wraps at 32 bits
          g.addr = heap_base + ffba_pkg::ADDR_W'(first * BLOCK_BYTES);
        end
      end
      return g;
    endfunction

    function void log_request(logic [ffba_pkg::REQ_W-1:0] bytes);
      owed_grants.push_back(first_fit_grant(bytes));
    endfunction

    function void match_grant(logic [ffba_pkg::ADDR_W-1:0] addr, logic [1:0] st);
      grant_t want;
      if (owed_grants.size() == 0) begin
        $error("result item with no request waiting: block_address %h status %0d", addr, st);
        errors++;
        return;
      end
      want = owed_grants.pop_front();
      if (addr !== want.addr) begin
        $error("block_address: expected %h, got %h", want.addr, addr);
        errors++;
      end
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        errors++;
      end
    endfunction
  endclass

  alloc_ledger ledger = new();

  first_fit_block_allocator_unit #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .request_bytes_i (req_bytes),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .block_address_o (block_address),
    .status_o        (status)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop, several times the slowest legal run
  initial begin
    #(64'd50_000_000);
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned idle_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  // mostly one to three blocks, some medium runs, some zero-size and some
  // oversized requests with the top bit set, which need at least the whole table
  function automatic logic [ffba_pkg::REQ_W-1:0] random_request();
    int unsigned                pick, nblk;
    logic [ffba_pkg::REQ_W-1:0] r;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      r = '0;
    end else if (pick < 12) begin
      r = ffba_pkg::REQ_W'($urandom());
      r[ffba_pkg::REQ_W-1] = 1'b1;
    end else begin
      nblk = (pick < 17) ? $urandom_range(4, 40) : $urandom_range(1, 3);
      r = ffba_pkg::REQ_W'((nblk - 1) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES));
    end
    return r;
  endfunction

  // register write, issued after a drain or during the clear pass after reset
  task automatic write_reg(input logic [ffba_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ffba_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    ledger.write_reg(idx, data);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // one request item; valid stays high across back-to-back items
  task automatic send_request(input logic [ffba_pkg::REQ_W-1:0] bytes);
    int unsigned gap;
    gap = idle_gap(tx_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    req_bytes = bytes;
    do @(posedge clk); while (in_ready !== 1'b1);
    ledger.log_request(bytes);
  endtask

  // sender holds off until every owed result has come back
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (ledger.owed_grants.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // result side: random stalls, with stretches of none
  initial begin
    int unsigned gap, cnt;
    cnt = 0;
    @(posedge rst_n);
    forever begin
      if (cnt % 20 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      cnt++;
      gap = idle_gap(rx_calm);
      @(negedge clk);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      ledger.match_grant(block_address, status);
    end
  end

  // stimulus
  initial begin
    int unsigned                 biu_pick;
    logic [ffba_pkg::CFG_W-1:0]  biu_word;
    logic [ffba_pkg::ADDR_W-1:0] base_pick;

    // reset held low from time zero, released once
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // tiny heap of 8 blocks: rounding, zero size, run cut short by the end
    write_reg(ffba_pkg::REG_HEAP_BASE, 32'h1000_0000);
    write_reg(ffba_pkg::REG_BLOCKS_IN_USE, 32'd8);
    send_request(23'd0);
    send_request(23'd1);
    send_request(23'd4096);
    send_request(23'd4097);
    send_request(23'd8192);
    send_request(23'd12288);      // 3 blocks, only 2 left before the end
    send_request(23'd36864);      // more blocks than covered
    send_request(23'd4194304);    // whole table
    send_request(23'h7f_ffff);    // largest field value
    send_request(23'd8191);       // fills the last two blocks
    send_request(23'd1);          // covered part is full
    drain();

    // no coverage at all, base at the top
    write_reg(ffba_pkg::REG_BLOCKS_IN_USE, 32'd0);
    write_reg(ffba_pkg::REG_HEAP_BASE, 32'hffff_ffff);
    send_request(23'd1);
    send_request(23'd0);
    drain();

    // coverage above the table size saturates; address wraps past 2^32
    write_reg(ffba_pkg::REG_BLOCKS_IN_USE, 32'd2047);
    write_reg(ffba_pkg::REG_HEAP_BASE, 32'hffff_f000);
    send_request(23'd4096);
    send_request(23'd2);
    send_request(23'd4194304);
    send_request(23'h55_5555);
    send_request(23'd20000);
    drain();

    // shrunk coverage over already taken entries
    write_reg(ffba_pkg::REG_BLOCKS_IN_USE, 32'd1);
    write_reg(ffba_pkg::REG_HEAP_BASE, 32'h0);
    send_request(23'd1);
    drain();
    write_reg(ffba_pkg::REG_BLOCKS_IN_USE, 32'd4);
    send_request(23'd4096);
    drain();

    // random phases, each with its own register setting
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0:       biu_pick = 1024;
        1:       biu_pick = 2047;
        2:       biu_pick = $urandom_range(1025, 2047);
        3:       biu_pick = $urandom_range(0, 64);
        4:       biu_pick = 1024;
        default: biu_pick = $urandom_range(700, 1023);
      endcase
      case (p)
        0:       base_pick = '0;
        1:       base_pick = '1;
        default: base_pick = $urandom();
      endcase
      // bits above the register width are don't-care
      biu_word = $urandom();
      biu_word[ffba_pkg::BIU_W-1:0] = biu_pick[ffba_pkg::BIU_W-1:0];
      write_reg(ffba_pkg::REG_HEAP_BASE, base_pick);
      write_reg(ffba_pkg::REG_BLOCKS_IN_USE, biu_word);
      for (int n = 0; n < 75; n++) begin
        if (n % 25 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        // mid-phase hold-off until the pipe is empty
        if (n == 40) drain();
        send_request(random_request());
      end
    end

    // let everything come back, then watch for stray results
    drain();
    repeat (2100) @(posedge clk);
    if (ledger.errors == 0 && ledger.owed_grants.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
